// ----- rtl/core/lcf_pkg.sv -----
// ----------------------------------------------------------------------------
// lcf_pkg: lifecycle controller shared types and constants
// State and event codes, the item structs of both channels and the decoded
// transition record passed between the table decode and the state tracker.
// ----------------------------------------------------------------------------
package lcf_pkg;

	localparam int unsigned STATE_W = 4;
	localparam int unsigned EVENT_W = 5;
	localparam int unsigned TIME_W  = 64;
	localparam int unsigned COUNT_W = 32;

	// Action codes
	localparam logic ACT_APPLY = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	typedef enum logic [STATE_W-1:0] {
		ST_BOOT        = 4'd0,
		ST_SELFTEST    = 4'd1,
		ST_NETWORK     = 4'd2,
		ST_REGISTERING = 4'd3,
		ST_READY       = 4'd4,
		ST_CALIBRATION = 4'd5,
		ST_MAINTENANCE = 4'd6,
		ST_GAME_PREP   = 4'd7,
		ST_COUNTDOWN   = 4'd8,
		ST_ACTIVE      = 4'd9,
		ST_PAUSED      = 4'd10,
		ST_FINISHED    = 4'd11,
		ST_ERROR       = 4'd12
	} state_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_SELFTEST_START   = 5'd0,
		EV_SELFTEST_OK      = 5'd1,
		EV_SELFTEST_FAIL    = 5'd2,
		EV_LINK_UP          = 5'd3,
		EV_LINK_DOWN        = 5'd4,
		EV_MQTT_CONNECTED   = 5'd5,
		EV_MQTT_DISCONN     = 5'd6,
		EV_REGISTERED       = 5'd7,
		EV_REGISTER_TIMEOUT = 5'd8,
		EV_CAL_START        = 5'd9,
		EV_CAL_END          = 5'd10,
		EV_MAINT_ON         = 5'd11,
		EV_MAINT_OFF        = 5'd12,
		EV_GAME_PREPARE     = 5'd13,
		EV_GAME_COUNTDOWN   = 5'd14,
		EV_GAME_START       = 5'd15,
		EV_GAME_PAUSE       = 5'd16,
		EV_GAME_RESUME      = 5'd17,
		EV_GAME_FINISH      = 5'd18,
		EV_GAME_ABORT       = 5'd19,
		EV_ERROR_RAISED     = 5'd20,
		EV_ERROR_CLEARED    = 5'd21,
		EV_NONE             = 5'd22
	} event_t;

	typedef struct packed {
		logic               action;
		logic [EVENT_W-1:0] event_code;
		logic [TIME_W-1:0]  now_time;
	} evt_item_t;

	typedef struct packed {
		logic               accepted;
		logic [STATE_W-1:0] current_state;
		logic [STATE_W-1:0] prior_state;
		logic [COUNT_W-1:0] transition_total;
		logic [COUNT_W-1:0] rejected_total;
		logic [EVENT_W-1:0] last_rejected;
		logic [TIME_W-1:0]  entered_time;
		logic               game_in_progress;
		logic               accepts_hits;
	} rpt_item_t;

	// Transition table lookup result
	typedef struct packed {
		logic   hit;
		state_t dest;
	} arc_t;

endpackage

// ----- rtl/core/lcf_arc_decode.sv -----
// ----------------------------------------------------------------------------
// lcf_arc_decode: transition table
// Constant decode of the 44 arcs: is there a move from this state on this
// event, and where does it lead.
// ----------------------------------------------------------------------------
module lcf_arc_decode
	import lcf_pkg::*;
(
	input  state_t             mode,
	input  logic [EVENT_W-1:0] event_code,
	output arc_t               arc
);

	logic   hit;
	state_t dest;

	always_comb begin
		hit  = 1'b1;
		dest = ST_BOOT;
		unique case (mode)
			ST_BOOT: begin
				unique case (event_code)
					EV_SELFTEST_START: dest = ST_SELFTEST;
					EV_ERROR_RAISED:   dest = ST_ERROR;
					default:           hit  = 1'b0;
				endcase
			end
			ST_SELFTEST: begin
				unique case (event_code)
					EV_SELFTEST_OK:                    dest = ST_NETWORK;
					EV_SELFTEST_FAIL, EV_ERROR_RAISED: dest = ST_ERROR;
					default:                           hit  = 1'b0;
				endcase
			end
			ST_NETWORK: begin
				// link up/down are self moves, still counted
				unique case (event_code)
					EV_LINK_UP, EV_LINK_DOWN: dest = ST_NETWORK;
					EV_MQTT_CONNECTED:        dest = ST_REGISTERING;
					EV_ERROR_RAISED:          dest = ST_ERROR;
					default:                  hit  = 1'b0;
				endcase
			end
			ST_REGISTERING: begin
				unique case (event_code)
					EV_REGISTERED:                        dest = ST_READY;
					EV_REGISTER_TIMEOUT, EV_ERROR_RAISED: dest = ST_ERROR;
					EV_MQTT_DISCONN:                      dest = ST_NETWORK;
					default:                              hit  = 1'b0;
				endcase
			end
			ST_READY: begin
				unique case (event_code)
					EV_CAL_START:                  dest = ST_CALIBRATION;
					EV_MAINT_ON:                   dest = ST_MAINTENANCE;
					EV_GAME_PREPARE:               dest = ST_GAME_PREP;
					EV_MQTT_DISCONN, EV_LINK_DOWN: dest = ST_NETWORK;
					EV_ERROR_RAISED:               dest = ST_ERROR;
					default:                       hit  = 1'b0;
				endcase
			end
			ST_CALIBRATION: begin
				unique case (event_code)
					EV_CAL_END:      dest = ST_READY;
					EV_ERROR_RAISED: dest = ST_ERROR;
					default:         hit  = 1'b0;
				endcase
			end
			ST_MAINTENANCE: begin
				unique case (event_code)
					EV_MAINT_OFF:    dest = ST_READY;
					EV_ERROR_RAISED: dest = ST_ERROR;
					default:         hit  = 1'b0;
				endcase
			end
			ST_GAME_PREP: begin
				unique case (event_code)
					EV_GAME_COUNTDOWN: dest = ST_COUNTDOWN;
					EV_GAME_ABORT:     dest = ST_READY;
					EV_ERROR_RAISED:   dest = ST_ERROR;
					default:           hit  = 1'b0;
				endcase
			end
			ST_COUNTDOWN: begin
				unique case (event_code)
					EV_GAME_START:   dest = ST_ACTIVE;
					EV_GAME_ABORT:   dest = ST_READY;
					EV_ERROR_RAISED: dest = ST_ERROR;
					default:         hit  = 1'b0;
				endcase
			end
			ST_ACTIVE: begin
				unique case (event_code)
					EV_GAME_PAUSE, EV_MQTT_DISCONN: dest = ST_PAUSED;
					EV_GAME_FINISH, EV_GAME_ABORT:  dest = ST_FINISHED;
					EV_ERROR_RAISED:                dest = ST_ERROR;
					default:                        hit  = 1'b0;
				endcase
			end
			ST_PAUSED: begin
				unique case (event_code)
					EV_GAME_RESUME:                dest = ST_ACTIVE;
					EV_GAME_FINISH, EV_GAME_ABORT: dest = ST_FINISHED;
					EV_ERROR_RAISED:               dest = ST_ERROR;
					default:                       hit  = 1'b0;
				endcase
			end
			ST_FINISHED: begin
				unique case (event_code)
					EV_GAME_PREPARE: dest = ST_GAME_PREP;
					EV_GAME_ABORT:   dest = ST_READY;
					EV_MAINT_ON:     dest = ST_MAINTENANCE;
					EV_ERROR_RAISED: dest = ST_ERROR;
					default:         hit  = 1'b0;
				endcase
			end
			ST_ERROR: begin
				unique case (event_code)
					EV_ERROR_CLEARED: dest = ST_SELFTEST;
					EV_MAINT_ON:      dest = ST_MAINTENANCE;
					default:          hit  = 1'b0;
				endcase
			end
			default: hit = 1'b0;
		endcase
	end

	assign arc = '{hit: hit, dest: dest};

endmodule

// ----- rtl/core/lcf_tracker.sv -----
// ----------------------------------------------------------------------------
// lcf_tracker: lifecycle state and statistics
// Holds mode, prior mode, counters, last rejected event and entry time;
// commits one item per strobe and forms its report from the updated values.
// ----------------------------------------------------------------------------
module lcf_tracker
	import lcf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      commit,
	input  evt_item_t item,
	output rpt_item_t rpt
);

	state_t             mode_q, prior_q, mode_d, prior_d;
	logic [COUNT_W-1:0] acc_cnt_q, rej_cnt_q, acc_cnt_d, rej_cnt_d;
	logic [EVENT_W-1:0] last_bad_q, last_bad_d;
	logic [TIME_W-1:0]  stamp_q, stamp_d;
	arc_t               arc;

	lcf_arc_decode u_arc_decode (
		.mode       (mode_q),
		.event_code (item.event_code),
		.arc        (arc)
	);

	always_comb begin
		mode_d     = mode_q;
		prior_d    = prior_q;
		acc_cnt_d  = acc_cnt_q;
		rej_cnt_d  = rej_cnt_q;
		last_bad_d = last_bad_q;
		stamp_d    = stamp_q;
		if (item.action == ACT_APPLY) begin
			if (arc.hit) begin
				prior_d   = mode_q;
				mode_d    = arc.dest;
				acc_cnt_d = acc_cnt_q + COUNT_W'(1);
				stamp_d   = item.now_time;
			end else begin
				rej_cnt_d  = rej_cnt_q + COUNT_W'(1);
				last_bad_d = item.event_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= ST_BOOT;
			prior_q    <= ST_BOOT;
			acc_cnt_q  <= '0;
			rej_cnt_q  <= '0;
			last_bad_q <= EV_NONE;
			stamp_q    <= '0;
		end else if (commit) begin
			mode_q     <= mode_d;
			prior_q    <= prior_d;
			acc_cnt_q  <= acc_cnt_d;
			rej_cnt_q  <= rej_cnt_d;
			last_bad_q <= last_bad_d;
			stamp_q    <= stamp_d;
		end
	end

	always_comb begin
		rpt.accepted         = arc.hit;
		rpt.current_state    = mode_d;
		rpt.prior_state      = prior_d;
		rpt.transition_total = acc_cnt_d;
		rpt.rejected_total   = rej_cnt_d;
		rpt.last_rejected    = last_bad_d;
		rpt.entered_time     = stamp_d;
		rpt.game_in_progress = (mode_d == ST_GAME_PREP) || (mode_d == ST_COUNTDOWN) ||
		                       (mode_d == ST_ACTIVE)    || (mode_d == ST_PAUSED);
		rpt.accepts_hits     = (mode_d == ST_ACTIVE) || (mode_d == ST_CALIBRATION);
	end

endmodule

// ----- rtl/core/module_lifecycle_fsm.sv -----
// ----------------------------------------------------------------------------
// module_lifecycle_fsm: lifecycle controller top level
// 13-state lifecycle machine driven by event items; each item is applied or
// only checked against the transition table and yields one report item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  evt     | in        | evt_valid, evt_stall | evt (evt_item_t)
//  rpt     | out       | rpt_valid, rpt_stall | rpt (rpt_item_t)
//
// A taken evt item passes the input register and then the report register,
// where rpt_valid marks its report; one item per cycle is sustained while rpt_stall is low.
// The rate is set by the combinational table decode and state
// update between the input register and the report register.
// An event item is committed to the state registers when it moves into the
// report register, so the next item always sees the updated state.
// rpt_stall holds the report register; the input register then fills and
// evt_stall rises, with no item dropped or repeated.
// arst_n clears both valid flags and the lifecycle state (boot, counters 0,
// last rejected event = none, entry time 0).
// ----------------------------------------------------------------------------
module module_lifecycle_fsm
	import lcf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_stall,
	input  evt_item_t evt,
	output logic      rpt_valid,
	input  logic      rpt_stall,
	output rpt_item_t rpt
);

	// Stage 1: registered event item
	logic      valid_s1;
	evt_item_t item_s1;
	// Stage 2: registered report item
	logic      valid_s2;
	rpt_item_t rpt_s2;
	rpt_item_t rpt_next;

	logic evt_take;
	logic advance;

	// Stage 1 moves on whenever the report register is empty or drains now
	assign advance   = valid_s1 && (!valid_s2 || !rpt_stall);
	assign evt_stall = valid_s1 && !advance;
	assign evt_take  = evt_valid && !evt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			item_s1 <= evt;
		end
	end

	// State update and report formation
	lcf_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.item   (item_s1),
		.rpt    (rpt_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!rpt_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rpt_s2 <= rpt_next;
		end
	end

	assign rpt_valid = valid_s2;
	assign rpt       = rpt_s2;

endmodule

// ----- rtl/core/lcf_checker.sv -----
// ----------------------------------------------------------------------------
// lcf_checker: port-level checks for the lifecycle controller
// Watches both channels for handshake holding and the report for state range and flag coherence.
// ----------------------------------------------------------------------------
module lcf_checker
	import lcf_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      evt_valid,
	input logic      evt_stall,
	input evt_item_t evt,
	input logic      rpt_valid,
	input logic      rpt_stall,
	input rpt_item_t rpt
);

	// A stalled event item stays put
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_stall |=> evt_valid && $stable(evt))
		else $error("event item changed while stalled");

	// A stalled report stays put
	a_rpt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt_stall |=> rpt_valid && $stable(rpt))
		else $error("report changed while stalled");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |-> rpt.current_state <= ST_ERROR && rpt.prior_state <= ST_ERROR)
		else $error("report state out of range");

	a_game_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt.game_in_progress |->
			rpt.current_state == ST_GAME_PREP || rpt.current_state == ST_COUNTDOWN ||
			rpt.current_state == ST_ACTIVE || rpt.current_state == ST_PAUSED)
		else $error("game flag outside a game state");

	a_hits_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt.accepts_hits |->
			rpt.current_state == ST_ACTIVE || rpt.current_state == ST_CALIBRATION)
		else $error("hit acceptance outside active or calibration");

endmodule

bind module_lifecycle_fsm lcf_checker u_lcf_checker (.*);
